// ===== src/pes_pkg.sv =====
// shared constants and helpers for the pdf string escaper
package pes_pkg;

    localparam int unsigned ByteW   = 8;
    localparam int unsigned RunMax  = 6;
    localparam int unsigned RunCntW = $clog2(RunMax + 1);
    localparam int unsigned RunIdxW = $clog2(RunMax);

    localparam logic [ByteW-1:0] ChLitOpen  = 8'h28;  // (
    localparam logic [ByteW-1:0] ChLitClose = 8'h29;  // )
    localparam logic [ByteW-1:0] ChHexOpen  = 8'h3c;  // <
    localparam logic [ByteW-1:0] ChHexClose = 8'h3e;  // >
    localparam logic [ByteW-1:0] ChBslash   = 8'h5c;  // backslash
    localparam logic [ByteW-1:0] ChZero     = 8'h30;  // 0
    localparam logic [ByteW-1:0] ChLowA     = 8'h61;  // a
    localparam logic [ByteW-1:0] PrintLo    = 8'd32;
    localparam logic [ByteW-1:0] PrintHi    = 8'd126;

    // one accepted input item plus the mode it is encoded under
    typedef struct packed {
        logic [ByteW-1:0] data;
        logic             first;
        logic             last;
        logic             empty;
        logic             hex;
    } t_item;

    // lower-case hex digit for one nibble
    function automatic logic [ByteW-1:0] hex_digit(input logic [3:0] nib);
        logic [ByteW-1:0] r;
        if (nib < 4'd10) begin
            r = ChZero + {4'd0, nib};
        end else begin
            r = ChLowA + {4'd0, nib - 4'd10};
        end
        return r;
    endfunction

    // octal digit character for three bits
    function automatic logic [ByteW-1:0] oct_digit(input logic [2:0] val);
        return ChZero + {5'd0, val};
    endfunction

endpackage

// ===== src/pdf_string_escaper_top.sv =====
// pdf string escaper: one raw byte in, its pdf string text out byte by byte
//
// Each input beat expands to between one and six output beats: an optional
// opening delimiter, the encoded byte (one char plain, two for a backslash
// prefix or a hex pair, four for an octal escape) and an optional closing
// delimiter. A beat can be taken every cycle while runs are one byte and the
// output is not stalled; a longer run holds the input until its last byte
// is taken, the port draining one byte per cycle while i_out_stall is low.
// A one-entry input register lets the next beat be taken while the current
// run drains. hex_mode is set by config and captured with each input beat.
module pdf_string_escaper_top (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // configuration
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic                      i_hex_mode,
    // input channel
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  logic [pes_pkg::ByteW-1:0] i_data_byte,
    input  logic                      i_first_byte,
    input  logic                      i_last_byte,
    input  logic                      i_empty_string,
    // output channel
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output logic [pes_pkg::ByteW-1:0] o_out_byte,
    output logic                      o_run_end,
    output logic                      o_string_end
);
    import pes_pkg::*;

    logic                r_hex;
    logic                r_in_valid;
    t_item               r_in;
    logic                r_out_valid;
    logic [ByteW-1:0]    r_run [RunMax];
    logic [RunCntW-1:0]  r_cnt;
    logic [RunIdxW-1:0]  r_idx;
    logic                r_close;

    logic [ByteW-1:0]    n_run [RunMax];
    logic [RunCntW-1:0]  n_cnt;
    logic                n_close;

    logic                in_fire;
    logic                out_fire;
    logic                out_last;
    logic                load_run;

    // config register, always ready
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hex <= 1'b0;
        end else if (i_cfg_valid) begin
            r_hex <= i_hex_mode;
        end
    end

    // handshake control
    assign out_last = (r_idx == RunIdxW'(r_cnt - RunCntW'(1)));
    assign out_fire = r_out_valid && !i_out_stall;
    assign load_run = r_in_valid && (!r_out_valid || (out_fire && out_last));
    assign o_in_stall = r_in_valid && !load_run;
    assign in_fire = i_in_valid && !o_in_stall;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_fire) begin
            r_in_valid <= 1'b1;
        end else if (load_run) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_in.data  <= i_data_byte;
            r_in.first <= i_first_byte;
            r_in.last  <= i_last_byte;
            r_in.empty <= i_empty_string;
            r_in.hex   <= r_hex;
        end
    end

    // build the output run for the held item
    always_comb begin
        logic [ByteW-1:0]   opener;
        logic [ByteW-1:0]   closer;
        logic [RunCntW-1:0] k;
        opener = r_in.hex ? ChHexOpen : ChLitOpen;
        closer = r_in.hex ? ChHexClose : ChLitClose;
        k = '0;
        for (int i = 0; i < RunMax; i++) begin
            n_run[i] = '0;
        end
        n_close = 1'b0;
        if (r_in.empty) begin
            n_run[0] = opener;
            n_run[1] = closer;
            k = RunCntW'(2);
            n_close = 1'b1;
        end else begin
            if (r_in.first) begin
                n_run[k[RunIdxW-1:0]] = opener;
                k = k + RunCntW'(1);
            end
            if (r_in.hex) begin
                n_run[k[RunIdxW-1:0]] = hex_digit(r_in.data[7:4]);
                k = k + RunCntW'(1);
                n_run[k[RunIdxW-1:0]] = hex_digit(r_in.data[3:0]);
                k = k + RunCntW'(1);
            end else if (r_in.data < PrintLo || r_in.data > PrintHi) begin
                n_run[k[RunIdxW-1:0]] = ChBslash;
                k = k + RunCntW'(1);
                n_run[k[RunIdxW-1:0]] = oct_digit({1'b0, r_in.data[7:6]});
                k = k + RunCntW'(1);
                n_run[k[RunIdxW-1:0]] = oct_digit(r_in.data[5:3]);
                k = k + RunCntW'(1);
                n_run[k[RunIdxW-1:0]] = oct_digit(r_in.data[2:0]);
                k = k + RunCntW'(1);
            end else if (r_in.data == ChLitOpen || r_in.data == ChLitClose
                         || r_in.data == ChBslash) begin
                n_run[k[RunIdxW-1:0]] = ChBslash;
                k = k + RunCntW'(1);
                n_run[k[RunIdxW-1:0]] = r_in.data;
                k = k + RunCntW'(1);
            end else begin
                n_run[k[RunIdxW-1:0]] = r_in.data;
                k = k + RunCntW'(1);
            end
            if (r_in.last) begin
                n_run[k[RunIdxW-1:0]] = closer;
                k = k + RunCntW'(1);
                n_close = 1'b1;
            end
        end
        n_cnt = k;
    end

    // run buffer and read pointer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_idx       <= '0;
        end else if (load_run) begin
            r_out_valid <= 1'b1;
            r_idx       <= '0;
        end else if (out_fire) begin
            if (out_last) begin
                r_out_valid <= 1'b0;
                r_idx       <= '0;
            end else begin
                r_idx <= r_idx + RunIdxW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_run) begin
            r_run   <= n_run;
            r_cnt   <= n_cnt;
            r_close <= n_close;
        end
    end

    // output beat
    assign o_out_valid  = r_out_valid;
    assign o_out_byte   = r_run[r_idx];
    assign o_run_end    = out_last;
    assign o_string_end = out_last && r_close;

endmodule

// ===== src/pes_checker.sv =====
// port-level checks for the pdf string escaper, bound to the top level
module pes_checker (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      i_in_valid,
    input logic                      o_in_stall,
    input logic                      o_out_valid,
    input logic                      i_out_stall,
    input logic [pes_pkg::ByteW-1:0] o_out_byte,
    input logic                      o_run_end,
    input logic                      o_string_end
);
    import pes_pkg::*;

    // a stalled output beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_byte)
            && $stable(o_run_end) && $stable(o_string_end))
        else $error("stalled output beat changed");

    // string end only on the last beat of a run
    a_end_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_string_end |-> o_run_end)
        else $error("string end before run end");

    // string end only on a closing delimiter
    a_end_char: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_string_end |-> (o_out_byte == ChLitClose
            || o_out_byte == ChHexClose))
        else $error("string end on a non-delimiter byte");

    // nothing on the output right after reset
    a_rst_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    // the input only stalls while a run is being drained
    a_run_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_stall |-> o_out_valid)
        else $error("input stalled with no output run");

endmodule

bind pdf_string_escaper_top pes_checker u_pes_checker (.*);
